/* rtl/core/ccr_pkg.sv */
// Shared types and constants of the circle canvas rasterizer.
`default_nettype none

package ccr_pkg;

    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 24;
    localparam int CODE_W   = 8;
    localparam int RDADDR_W = 8;
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 2;
    localparam int DIM_W    = 11;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OUTLINE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILLED  = 2'd1;

    localparam logic [IDX_W-1:0] REG_WIDTH      = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT     = 2'd1;
    localparam logic [IDX_W-1:0] REG_BACKGROUND = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd256;
    localparam logic [CODE_W-1:0] BG_RST     = 8'd32;

    typedef struct packed {
        logic load;
        logic setup_mag;
        logic setup_sq;
        logic walk_step;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            draw_skip;
        logic            canvas_empty;
        logic            walk_last;
        logic            walk_home;
        logic            pipe_busy;
        logic            out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/ccr_ctrl.sv */
// Command sequencer of the circle canvas rasterizer.
`default_nettype none

module ccr_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ccr_pkg::dp_status_t sts,
    output ccr_pkg::ctrl_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SETUP1 = 3'd3;
    localparam logic [2:0] ST_SETUP2 = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.op)
                    ccr_pkg::OP_CLEAR:
                        state_next = sts.canvas_empty ? ST_FINISH : ST_WALK;
                    ccr_pkg::OP_DRAW:
                        state_next = (sts.canvas_empty || sts.draw_skip) ? ST_FINISH
                                                                          : ST_SETUP1;
                    ccr_pkg::OP_READ:
                        state_next = ST_READ;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_READ:
                state_next = ST_FINISH;
            ST_SETUP1:
            begin
                cmd.setup_mag = 1'b1;
                state_next    = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                cmd.setup_sq = 1'b1;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> sts.out_free)
        else $error("result loaded while output register full");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sts.pipe_busy)
        else $error("pixel pipeline busy while idle");

    a_idle_walk_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> sts.walk_home)
        else $error("scan counters not at origin while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded");

endmodule

`default_nettype wire

/* rtl/core/ccr_datapath.sv */
// Canvas memory, scan counters, pixel distance pipeline and result register.
`default_nettype none

module ccr_datapath
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ccr_pkg::ctrl_cmd_t                 cmd,
    output ccr_pkg::dp_status_t                     sts,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ccr_pkg::IDX_W-1:0]          cfg_addr,
    input  wire logic [ccr_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic [ccr_pkg::OP_W-1:0]           in_opcode,
    input  wire logic [ccr_pkg::KIND_W-1:0]         in_shape_kind,
    input  wire logic [ccr_pkg::COORD_W-1:0]        in_center_x,
    input  wire logic [ccr_pkg::COORD_W-1:0]        in_center_y,
    input  wire logic [ccr_pkg::COORD_W-1:0]        in_radius,
    input  wire logic [ccr_pkg::CODE_W-1:0]         in_paint_code,
    input  wire logic [ccr_pkg::RDADDR_W-1:0]       in_read_row,
    input  wire logic [ccr_pkg::RDADDR_W-1:0]       in_read_col,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [ccr_pkg::CODE_W-1:0]              out_cell_code,
    output logic                                    out_row_end,
    output logic                                    out_status
);

    localparam int COORD_W = ccr_pkg::COORD_W;
    localparam int CODE_W  = ccr_pkg::CODE_W;
    localparam int DIM_W   = ccr_pkg::DIM_W;
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int LINE_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int POS_W   = LINE_W + FRAC_BITS;
    localparam int SUB_W   = ((POS_W + 1 > COORD_W) ? POS_W + 1 : COORD_W) + 1;
    localparam int MAG_W   = SUB_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int R2_W    = 2 * COORD_W;
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);
    localparam logic signed [COORD_W:0] ONE_Q = (COORD_W+1)'(1 << FRAC_BITS);

    // configuration
    logic [ccr_pkg::CFG_W-1:0] cfg_width_reg;
    logic [ccr_pkg::CFG_W-1:0] cfg_height_reg;
    logic [CODE_W-1:0]         bg_code_reg;
    logic [DIM_W-1:0]          used_w;
    logic [DIM_W-1:0]          used_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= ccr_pkg::WIDTH_RST;
            cfg_height_reg <= ccr_pkg::HEIGHT_RST;
            bg_code_reg    <= ccr_pkg::BG_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                ccr_pkg::REG_WIDTH:      cfg_width_reg  <= cfg_wdata;
                ccr_pkg::REG_HEIGHT:     cfg_height_reg <= cfg_wdata;
                ccr_pkg::REG_BACKGROUND: bg_code_reg    <= cfg_wdata[CODE_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign used_w = (DIM_W'(cfg_width_reg) > MAX_W_D) ? MAX_W_D : DIM_W'(cfg_width_reg);
    assign used_h = (DIM_W'(cfg_height_reg) > MAX_H_D) ? MAX_H_D : DIM_W'(cfg_height_reg);

    // request capture
    logic [ccr_pkg::OP_W-1:0]     op_reg;
    logic [ccr_pkg::KIND_W-1:0]   kind_reg;
    logic [COORD_W-1:0]           cx_reg;
    logic [COORD_W-1:0]           cy_reg;
    logic [COORD_W-1:0]           r_reg;
    logic [CODE_W-1:0]            paint_reg;
    logic [ccr_pkg::RDADDR_W-1:0] rrow_reg;
    logic [ccr_pkg::RDADDR_W-1:0] rcol_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_opcode;
            kind_reg  <= in_shape_kind;
            cx_reg    <= in_center_x;
            cy_reg    <= in_center_y;
            r_reg     <= in_radius;
            paint_reg <= in_paint_code;
            rrow_reg  <= in_read_row;
            rcol_reg  <= in_read_col;
        end
    end

    // radius squares
    logic signed [COORD_W:0] rm1;
    logic [COORD_W-1:0]      rin_mag;
    logic [COORD_W-1:0]      rin_mag_reg;
    logic                    small_reg;
    logic [R2_W-1:0]         r2_reg;
    logic [R2_W-1:0]         rin2_reg;

    assign rm1     = $signed({r_reg[COORD_W-1], r_reg}) - ONE_Q;
    assign rin_mag = rm1[COORD_W] ? COORD_W'(-rm1) : rm1[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.setup_mag)
        begin
            rin_mag_reg <= rin_mag;
            small_reg   <= rm1[COORD_W];
        end
        if (cmd.setup_sq)
        begin
            r2_reg   <= R2_W'(r_reg) * R2_W'(r_reg);
            rin2_reg <= R2_W'(rin_mag_reg) * R2_W'(rin_mag_reg);
        end
    end

    // scan counters
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             col_last;
    logic             row_last;

    assign col_last = (DIM_W'(col_reg) == used_w - DIM_W'(1));
    assign row_last = (DIM_W'(row_reg) == used_h - DIM_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.walk_step)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // pixel pipeline: offsets, squares, test
    logic signed [SUB_W-1:0] dx;
    logic signed [SUB_W-1:0] dy;
    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic [ADDR_W-1:0]       s2_addr_reg;
    logic [ADDR_W-1:0]       s3_addr_reg;
    logic [MAG_W-1:0]        s1_dx_mag_reg;
    logic [MAG_W-1:0]        s1_dy_mag_reg;
    logic [SQ_W-1:0]         s2_dx2_reg;
    logic [SQ_W-1:0]         s2_dy2_reg;
    logic                    s3_hit_reg;
    logic [D2_W-1:0]         d2;
    logic                    in_disc;
    logic                    hit;
    logic [CODE_W-1:0]       wr_code;

    assign dx = $signed({{(SUB_W-COORD_W){cx_reg[COORD_W-1]}}, cx_reg})
              - $signed(SUB_W'(col_reg) << FRAC_BITS);
    assign dy = $signed({{(SUB_W-COORD_W){cy_reg[COORD_W-1]}}, cy_reg})
              - $signed(SUB_W'(row_reg) << FRAC_BITS);

    assign d2      = D2_W'(s2_dx2_reg) + D2_W'(s2_dy2_reg);
    assign in_disc = (d2 <= D2_W'(r2_reg));

    always_comb
    begin
        if (op_reg == ccr_pkg::OP_CLEAR)
            hit = 1'b1;
        else if (kind_reg == ccr_pkg::KIND_OUTLINE)
            hit = in_disc && (small_reg || (d2 > D2_W'(rin2_reg)));
        else
            hit = in_disc;
    end

    assign wr_code = (op_reg == ccr_pkg::OP_CLEAR) ? bg_code_reg : paint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.walk_step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= {row_reg, col_reg};
        s1_dx_mag_reg <= dx[SUB_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        s1_dy_mag_reg <= dy[SUB_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
        s2_addr_reg   <= s1_addr_reg;
        s2_dx2_reg    <= SQ_W'(s1_dx_mag_reg) * SQ_W'(s1_dx_mag_reg);
        s2_dy2_reg    <= SQ_W'(s1_dy_mag_reg) * SQ_W'(s1_dy_mag_reg);
        s3_addr_reg   <= s2_addr_reg;
        s3_hit_reg    <= hit;
    end

    // canvas memory
    logic [CODE_W-1:0] canvas_mem [0:(1<<ADDR_W)-1];
    logic [CODE_W-1:0] rd_data_reg;
    logic [DIM_W-1:0]  rd_row;
    logic [DIM_W-1:0]  rd_col;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_oob;

    assign rd_row  = DIM_W'(rrow_reg);
    assign rd_col  = DIM_W'(rcol_reg);
    assign rd_addr = {rd_row[ROW_W-1:0], rd_col[COL_W-1:0]};
    assign rd_oob  = (rd_row >= used_h) || (rd_col >= used_w);

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_hit_reg)
            canvas_mem[s3_addr_reg] <= wr_code;
        rd_data_reg <= canvas_mem[rd_addr];
    end

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_row_end_reg;
    logic              out_status_reg;
    logic              is_read;

    assign is_read = (op_reg == ccr_pkg::OP_READ);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_code_reg    <= (is_read && !rd_oob) ? rd_data_reg : '0;
            out_row_end_reg <= is_read && !rd_oob && ((rd_col + DIM_W'(1)) == used_w);
            out_status_reg  <= is_read && rd_oob;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cell_code = out_code_reg;
    assign out_row_end   = out_row_end_reg;
    assign out_status    = out_status_reg;

    // status to sequencer
    assign sts.op           = op_reg;
    assign sts.draw_skip    = r_reg[COORD_W-1] || (kind_reg > ccr_pkg::KIND_FILLED);
    assign sts.canvas_empty = (used_w == '0) || (used_h == '0);
    assign sts.walk_last    = col_last && row_last;
    assign sts.walk_home    = (col_reg == '0) && (row_reg == '0);
    assign sts.pipe_busy    = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign sts.out_free     = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

/* rtl/core/circle_canvas_rasterizer_core.sv */
// Top level of the circle canvas rasterizer: stream ports, sequencer and datapath.
`default_nettype none

// Character canvas of up to MAX_WIDTH x MAX_HEIGHT 8-bit cells with clear, circle
// draw and single-cell read requests; each request returns exactly one result.
// A clear or draw scans every cell in use at one cell per cycle, a draw first
// squaring its outer and inner radii; a draw with negative radius or unknown
// kind, a clear or draw on an empty canvas, or an unused opcode skips the scan,
// and a read fetches one cell. The scan rate is set by the single write port of
// the canvas memory, fed by a three-stage offset/square/compare pipeline.
// Requests are taken one at a time; a result waiting on m_tready holds the next
// request only at its final step. The canvas is undefined until the first clear.

module circle_canvas_rasterizer_core
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ccr_pkg::IDX_W-1:0]     cfg_addr,
    input  wire logic [ccr_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // center_x[23:0], center_y[47:24], radius[71:48], paint_code[79:72],
    // read_row[87:80], read_col[95:88]
    input  wire logic [95:0]                   s_tdata,
    // opcode[1:0], shape_kind[3:2]
    input  wire logic [3:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // cell_code[7:0]
    output logic [7:0]                         m_tdata,
    // row_end
    output logic                               m_tlast,
    // status[0]
    output logic                               m_tuser
);

    ccr_pkg::ctrl_cmd_t  cmd;
    ccr_pkg::dp_status_t sts;

    ccr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccr_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_opcode     (s_tuser[1:0]),
        .in_shape_kind (s_tuser[3:2]),
        .in_center_x   (s_tdata[23:0]),
        .in_center_y   (s_tdata[47:24]),
        .in_radius     (s_tdata[71:48]),
        .in_paint_code (s_tdata[79:72]),
        .in_read_row   (s_tdata[87:80]),
        .in_read_col   (s_tdata[95:88]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_cell_code (m_tdata),
        .out_row_end   (m_tlast),
        .out_status    (m_tuser)
    );

endmodule

`default_nettype wire
